// ----- rtl/core/aabb_pkg.sv -----
package aabb_pkg;

	// default coordinate width of vertices and box center
	localparam int COORD_BITS_DEF = 16;

	// configuration register index
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_HALF_X   = 3'd3,
		CFG_HALF_Y   = 3'd4,
		CFG_HALF_Z   = 3'd5
	} cfg_idx_t;

	// number of vertices and of coordinate axes
	localparam int NUM_VERT = 3;
	localparam int NUM_AXIS = 3;

endpackage

// ----- rtl/core/aabb_triangle_overlap_test.sv -----
// Triangle against axis-aligned box overlap test, separating axis theorem, 13 axes.
// Throughput: one triangle per cycle; the pipeline moves as one, so a stall on the
// output holds every stage and the input side waits with it.
// Reset (arst_n low, asynchronous): all stage valid bits cleared, box registers
// cleared to a zero center and zero half sizes.
module aabb_triangle_overlap_test #(
	parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [aabb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]          cfg_data,
	// triangle items
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// fields from bit 0 up: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
	input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	// result items
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// fields from bit 0 up: overlap, then zero fill
	output logic [7:0] m_axis_tdata
);

	import aabb_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int VW = C + 1;          // vertex relative to box center
	localparam int EW = C + 2;          // edge vector
	localparam int HW = C - 1;          // half size
	localparam int QW = VW + EW;        // one product of a projection
	localparam int PW = QW + 1;         // projection on an edge axis
	localparam int RQ = HW + EW;        // one product of an edge axis radius
	localparam int RW = RQ + 1;         // edge axis radius
	localparam int CW = PW + 1;         // compare width on edge axes
	localparam int NQ = 2 * EW;         // one product of the normal
	localparam int NW = NQ + 1;         // triangle normal component
	localparam int L  = C + 2;          // split point of the normal for the plane products
	localparam int NH = NW - L;         // upper part of the normal
	localparam int DLW = L + 1 + VW;    // low partial of n.v
	localparam int DHW = NH + VW;       // high partial of n.v
	localparam int RLW = HW + L;        // low partial of h.|n|
	localparam int RHW = HW + NH;       // high partial of h.|n|
	localparam int DW = 3 * C + 9;      // plane distance and radius
	localparam int FW = VW + 1;         // compare width on face axes

	// box registers
	logic signed [C-1:0]  center_q [NUM_AXIS];
	logic        [HW-1:0] half_q   [NUM_AXIS];

	// pipeline control
	logic ce;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// stage payloads
	logic signed [VW-1:0]  v_s1  [NUM_VERT][NUM_AXIS];
	logic signed [VW-1:0]  v_s2  [NUM_VERT][NUM_AXIS];
	logic signed [EW-1:0]  e_s2  [NUM_VERT][NUM_AXIS];
	logic                  sep_s2;
	logic signed [QW-1:0]  pa_s3 [NUM_VERT][NUM_AXIS][NUM_VERT];
	logic signed [QW-1:0]  pb_s3 [NUM_VERT][NUM_AXIS][NUM_VERT];
	logic        [RQ-1:0]  ra_s3 [NUM_VERT][NUM_AXIS];
	logic        [RQ-1:0]  rb_s3 [NUM_VERT][NUM_AXIS];
	logic signed [NQ-1:0]  na_s3 [NUM_AXIS];
	logic signed [NQ-1:0]  nb_s3 [NUM_AXIS];
	logic signed [VW-1:0]  v0_s3 [NUM_AXIS];
	logic                  sep_s3;
	logic signed [PW-1:0]  p_s4  [NUM_VERT][NUM_AXIS][NUM_VERT];
	logic        [RW-1:0]  r_s4  [NUM_VERT][NUM_AXIS];
	logic signed [NW-1:0]  n_s4  [NUM_AXIS];
	logic signed [VW-1:0]  v0_s4 [NUM_AXIS];
	logic                  sep_s4;
	logic signed [DLW-1:0] dl_s5 [NUM_AXIS];
	logic signed [DHW-1:0] dh_s5 [NUM_AXIS];
	logic        [RLW-1:0] rl_s5 [NUM_AXIS];
	logic        [RHW-1:0] rh_s5 [NUM_AXIS];
	logic                  sep_s5;
	logic signed [DW-1:0]  d_s6;
	logic signed [DW-1:0]  r_s6;
	logic                  sep_s6;
	logic                  ovl_s7;

	// combinational stage results
	logic signed [VW-1:0]  v_nx   [NUM_VERT][NUM_AXIS];
	logic signed [EW-1:0]  e_nx   [NUM_VERT][NUM_AXIS];
	logic                  face_sep;
	logic signed [QW-1:0]  pa_nx  [NUM_VERT][NUM_AXIS][NUM_VERT];
	logic signed [QW-1:0]  pb_nx  [NUM_VERT][NUM_AXIS][NUM_VERT];
	logic        [RQ-1:0]  ra_nx  [NUM_VERT][NUM_AXIS];
	logic        [RQ-1:0]  rb_nx  [NUM_VERT][NUM_AXIS];
	logic signed [NQ-1:0]  na_nx  [NUM_AXIS];
	logic signed [NQ-1:0]  nb_nx  [NUM_AXIS];
	logic signed [PW-1:0]  p_nx   [NUM_VERT][NUM_AXIS][NUM_VERT];
	logic        [RW-1:0]  r_nx   [NUM_VERT][NUM_AXIS];
	logic signed [NW-1:0]  n_nx   [NUM_AXIS];
	logic                  edge_sep;
	logic signed [DLW-1:0] dl_nx  [NUM_AXIS];
	logic signed [DHW-1:0] dh_nx  [NUM_AXIS];
	logic        [RLW-1:0] rl_nx  [NUM_AXIS];
	logic        [RHW-1:0] rh_nx  [NUM_AXIS];
	logic signed [DW-1:0]  d_nx;
	logic signed [DW-1:0]  r_nx6;
	logic                  ovl_nx;

	// The whole pipeline advances together; hold every stage while the output
	// item waits to be taken.
	assign ce            = !vld_s7 || m_axis_tready;
	assign s_axis_tready = ce;
	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = {7'd0, ovl_s7};

	// Box registers: unknown indices are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_AXIS; c++) begin
				center_q[c] <= '0;
				half_q[c]   <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X: center_q[0] <= cfg_data;
				CFG_CENTER_Y: center_q[1] <= cfg_data;
				CFG_CENTER_Z: center_q[2] <= cfg_data;
				CFG_HALF_X:   half_q[0]   <= cfg_data[HW-1:0];
				CFG_HALF_Y:   half_q[1]   <= cfg_data[HW-1:0];
				CFG_HALF_Z:   half_q[2]   <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 1: move the vertices so that the box center is the origin.
	always_comb begin
		for (int j = 0; j < NUM_VERT; j++) begin
			for (int c = 0; c < NUM_AXIS; c++) begin
				v_nx[j][c] = VW'($signed(s_axis_tdata[(3*j+c)*C +: C]))
					- VW'(center_q[c]);
			end
		end
	end

	// Stage 2: edges e_k = v_(k+1) - v_k, and the three box face axes.
	always_comb begin
		logic signed [FW-1:0] lo, hi, hs;
		face_sep = 1'b0;
		for (int k = 0; k < NUM_VERT; k++) begin
			for (int c = 0; c < NUM_AXIS; c++) begin
				e_nx[k][c] = EW'(v_s1[(k == 2) ? 0 : k + 1][c]) - EW'(v_s1[k][c]);
			end
		end
		for (int c = 0; c < NUM_AXIS; c++) begin
			lo = FW'(v_s1[0][c]);
			hi = FW'(v_s1[0][c]);
			for (int j = 1; j < NUM_VERT; j++) begin
				if (FW'(v_s1[j][c]) < lo) lo = FW'(v_s1[j][c]);
				if (FW'(v_s1[j][c]) > hi) hi = FW'(v_s1[j][c]);
			end
			hs = $signed(FW'(half_q[c]));
			if (lo > hs || hi < -hs) face_sep = 1'b1;
		end
	end

	// Stage 3: products of the edge axis projections and radii, and of the normal.
	always_comb begin
		logic        [EW-1:0] ae [NUM_VERT][NUM_AXIS];
		int c1, c2;
		for (int k = 0; k < NUM_VERT; k++) begin
			for (int c = 0; c < NUM_AXIS; c++) begin
				ae[k][c] = e_s2[k][c][EW-1] ? EW'(-e_s2[k][c]) : EW'(e_s2[k][c]);
			end
		end
		for (int k = 0; k < NUM_VERT; k++) begin
			for (int a = 0; a < NUM_AXIS; a++) begin
				// axis u_a x e_k touches the two other coordinates
				c1 = (a == 0) ? 2 : a - 1;
				c2 = (a == 2) ? 0 : a + 1;
				for (int j = 0; j < NUM_VERT; j++) begin
					pa_nx[k][a][j] = QW'(v_s2[j][c1]) * QW'(e_s2[k][c2]);
					pb_nx[k][a][j] = QW'(v_s2[j][c2]) * QW'(e_s2[k][c1]);
				end
				ra_nx[k][a] = RQ'(half_q[c2]) * RQ'(ae[k][c1]);
				rb_nx[k][a] = RQ'(half_q[c1]) * RQ'(ae[k][c2]);
			end
		end
		// normal n = e0 x e1
		for (int c = 0; c < NUM_AXIS; c++) begin
			c1 = (c == 2) ? 0 : c + 1;
			c2 = (c == 0) ? 2 : c - 1;
			na_nx[c] = NQ'(e_s2[0][c1]) * NQ'(e_s2[1][c2]);
			nb_nx[c] = NQ'(e_s2[0][c2]) * NQ'(e_s2[1][c1]);
		end
	end

	// Stage 4: finish the projections, radii and normal.
	always_comb begin
		for (int k = 0; k < NUM_VERT; k++) begin
			for (int a = 0; a < NUM_AXIS; a++) begin
				for (int j = 0; j < NUM_VERT; j++) begin
					p_nx[k][a][j] = PW'(pa_s3[k][a][j]) - PW'(pb_s3[k][a][j]);
				end
				r_nx[k][a] = RW'(ra_s3[k][a]) + RW'(rb_s3[k][a]);
			end
		end
		for (int c = 0; c < NUM_AXIS; c++) begin
			n_nx[c] = NW'(na_s3[c]) - NW'(nb_s3[c]);
		end
	end

	// Stage 5: edge axis tests; split products for the plane test.
	always_comb begin
		logic signed [CW-1:0] lo, hi, rs;
		logic        [NW-1:0] an;
		edge_sep = 1'b0;
		for (int k = 0; k < NUM_VERT; k++) begin
			for (int a = 0; a < NUM_AXIS; a++) begin
				lo = CW'(p_s4[k][a][0]);
				hi = CW'(p_s4[k][a][0]);
				for (int j = 1; j < NUM_VERT; j++) begin
					if (CW'(p_s4[k][a][j]) < lo) lo = CW'(p_s4[k][a][j]);
					if (CW'(p_s4[k][a][j]) > hi) hi = CW'(p_s4[k][a][j]);
				end
				rs = $signed(CW'(r_s4[k][a]));
				if (lo > rs || hi < -rs) edge_sep = 1'b1;
			end
		end
		for (int c = 0; c < NUM_AXIS; c++) begin
			an = n_s4[c][NW-1] ? NW'(-n_s4[c]) : NW'(n_s4[c]);
			rl_nx[c] = RLW'(half_q[c]) * RLW'(an[L-1:0]);
			rh_nx[c] = RHW'(half_q[c]) * RHW'(an[NW-1:L]);
			dl_nx[c] = DLW'($signed({1'b0, n_s4[c][L-1:0]})) * DLW'(v0_s4[c]);
			dh_nx[c] = DHW'($signed(n_s4[c][NW-1:L])) * DHW'(v0_s4[c]);
		end
	end

	// Stage 6: assemble the plane distance n.v0 and the radius h.|n|.
	always_comb begin
		d_nx  = '0;
		r_nx6 = '0;
		for (int c = 0; c < NUM_AXIS; c++) begin
			d_nx  = d_nx + (DW'(dh_s5[c]) <<< L) + DW'(dl_s5[c]);
			r_nx6 = r_nx6 + $signed(DW'(rh_s5[c]) << L) + $signed(DW'(rl_s5[c]));
		end
	end

	// Stage 7: plane test, touching counts as overlap.
	assign ovl_nx = !sep_s6 && ((r_s6 - d_s6) >= 0) && ((r_s6 + d_s6) >= 0);

	always_ff @(posedge clk) begin
		if (ce) begin
			v_s1   <= v_nx;
			v_s2   <= v_s1;
			e_s2   <= e_nx;
			sep_s2 <= face_sep;
			pa_s3  <= pa_nx;
			pb_s3  <= pb_nx;
			ra_s3  <= ra_nx;
			rb_s3  <= rb_nx;
			na_s3  <= na_nx;
			nb_s3  <= nb_nx;
			v0_s3  <= v_s2[0];
			sep_s3 <= sep_s2;
			p_s4   <= p_nx;
			r_s4   <= r_nx;
			n_s4   <= n_nx;
			v0_s4  <= v0_s3;
			sep_s4 <= sep_s3;
			dl_s5  <= dl_nx;
			dh_s5  <= dh_nx;
			rl_s5  <= rl_nx;
			rh_s5  <= rh_nx;
			sep_s5 <= sep_s4 || edge_sep;
			d_s6   <= d_nx;
			r_s6   <= r_nx6;
			sep_s6 <= sep_s5;
			ovl_s7 <= ovl_nx;
		end
	end

endmodule
